// ===== sv/scn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Spiral cell numbering package
// Shared constants, register indexes and stage payload types.
// ----------------------------------------------------------------------------
package scn_pkg;

   localparam int MAX_SIDE = 16;
   localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int VALUE_W  = 9;
   localparam int CSR_IDX_W = 3;

   localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

   localparam logic [CSR_IDX_W-1:0] CSR_SPIRAL_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIRAL_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_COLUMNS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_DOWN     = 3'd3;

   typedef struct packed {
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic              mirror;
      logic              count_down;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } query_type;

   typedef struct packed {
      logic                out_of_range;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  ring;
      logic                leftover;
      logic [SIDE_W-1:0]   inner_w;
      logic [SIDE_W-1:0]   inner_h;
      logic [VALUE_W-1:0]  area;
   } geom_type;

   typedef struct packed {
      logic                out_of_range;
      logic [VALUE_W-1:0]  base;
      logic [VALUE_W-1:0]  offset;
      logic [VALUE_W-1:0]  area;
   } offset_type;

   typedef struct packed {
      logic                out_of_range;
      logic [VALUE_W-1:0]  cell_value;
   } result_type;

endpackage
`default_nettype wire

// ===== sv/scn_geom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Spiral cell numbering, geometry stage
// Range check, column mirroring, ring depth and inner ring size.
// ----------------------------------------------------------------------------
module scn_geom
   import scn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire query_type  in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output geom_type        out_data
);

   logic               valid_ff;
   geom_type           data_ff;
   geom_type           data_in;
   logic [SIDE_W-1:0]  row_x;
   logic [SIDE_W-1:0]  col_x;
   logic [COORD_W-1:0] col_m;
   logic [COORD_W-1:0] dist_b;
   logic [COORD_W-1:0] dist_r;
   logic [COORD_W-1:0] dist_min;
   logic [SIDE_W-1:0]  side_min;
   logic [COORD_W-1:0] rings;
   logic [COORD_W-1:0] ring;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      row_x    = {1'b0, in_data.row};
      col_x    = {1'b0, in_data.col};
      col_m    = cfg.mirror ? COORD_W'(cfg.width - SIDE_W'(1) - col_x) : in_data.col;
      dist_b   = COORD_W'(cfg.height - SIDE_W'(1) - row_x);
      dist_r   = COORD_W'(cfg.width - SIDE_W'(1) - {1'b0, col_m});
      dist_min = (in_data.row < col_m) ? in_data.row : col_m;
      if (dist_b < dist_min) begin
         dist_min = dist_b;
      end
      if (dist_r < dist_min) begin
         dist_min = dist_r;
      end
      side_min = (cfg.width < cfg.height) ? cfg.width : cfg.height;
      rings    = COORD_W'(side_min >> 1);
      ring     = (dist_min < rings) ? dist_min : rings;

      data_in.out_of_range = (row_x >= cfg.height) || (col_x >= cfg.width);
      data_in.row          = in_data.row;
      data_in.col          = col_m;
      data_in.ring         = ring;
      data_in.leftover     = (dist_min >= rings);
      data_in.inner_w      = cfg.width - {ring, 1'b0};
      data_in.inner_h      = cfg.height - {ring, 1'b0};
      data_in.area         = VALUE_W'({{(VALUE_W-SIDE_W){1'b0}}, cfg.width}
                                      * {{(VALUE_W-SIDE_W){1'b0}}, cfg.height});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/scn_offset.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Spiral cell numbering, offset stage
// Cells in the outer rings and the position along the cell's own ring.
// ----------------------------------------------------------------------------
module scn_offset
   import scn_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire geom_type  in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output offset_type     out_data
);

   logic               valid_ff;
   offset_type         data_ff;
   offset_type         data_in;
   logic [VALUE_W-1:0] r9;
   logic [VALUE_W-1:0] c9;
   logic [VALUE_W-1:0] ring9;
   logic [VALUE_W-1:0] iw9;
   logic [VALUE_W-1:0] ih9;
   logic [VALUE_W-1:0] w9;
   logic [VALUE_W-1:0] h9;
   logic [VALUE_W-1:0] inner_area;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      r9    = VALUE_W'(in_data.row);
      c9    = VALUE_W'(in_data.col);
      ring9 = VALUE_W'(in_data.ring);
      iw9   = VALUE_W'(in_data.inner_w);
      ih9   = VALUE_W'(in_data.inner_h);
      w9    = VALUE_W'(cfg.width);
      h9    = VALUE_W'(cfg.height);
      inner_area = VALUE_W'(iw9 * ih9);

      data_in.out_of_range = in_data.out_of_range;
      data_in.area         = in_data.area;
      data_in.base         = in_data.area - inner_area;
      if (in_data.leftover) begin
         data_in.offset = (cfg.width > cfg.height) ? (c9 - ring9) : (r9 - ring9);
      end else if (r9 == ring9) begin
         data_in.offset = c9 - ring9;
      end else if (c9 == w9 - 9'd1 - ring9) begin
         data_in.offset = iw9 - 9'd1 + r9 - ring9;
      end else if (r9 == h9 - 9'd1 - ring9) begin
         data_in.offset = iw9 + ih9 - 9'd2 + (w9 - 9'd1 - ring9 - c9);
      end else begin
         data_in.offset = {iw9[VALUE_W-2:0], 1'b0} + ih9 - 9'd3 + (h9 - 9'd1 - ring9 - r9);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/scn_value.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Spiral cell numbering, value stage
// Spiral index and the final up or down count, held as the output word.
// ----------------------------------------------------------------------------
module scn_value
   import scn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire offset_type  in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output result_type       out_data
);

   logic               valid_ff;
   result_type         data_ff;
   result_type         data_in;
   logic [VALUE_W-1:0] index;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      index = in_data.base + in_data.offset;
      data_in.out_of_range = in_data.out_of_range;
      if (in_data.out_of_range) begin
         data_in.cell_value = '0;
      end else if (cfg.count_down) begin
         data_in.cell_value = in_data.area - index;
      end else begin
         data_in.cell_value = index + 9'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/spiral_cell_numbering_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Spiral cell numbering core
// Returns the number that a clockwise inward spiral fill places at a cell.
// ----------------------------------------------------------------------------
// Channel  Direction  Word
// req_     in         tdata[3:0] row, tdata[7:4] col
// rsp_     out        tdata[8:0] cell_value, tuser out_of_range
// csr_     in         index selects the register, wdata is the new value
//
// Three register stages: geometry, ring offset, final value.
// A query enters every cycle unless a held rsp_ word has filled the stages;
// its result word passes through the geometry, offset and value registers.
// The result register is the output, so a held rsp_ word stalls the stages
// behind it without losing or repeating a word.
// Reset clears the pipeline and sets a one by one grid, no mirror, count up.
// ----------------------------------------------------------------------------
module spiral_cell_numbering_core
   import scn_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // row, col
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,   // cell_value, zero fill
   output logic                       rsp_tuser,   // out_of_range
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SIDE_W-1:0]     csr_wdata
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [SIDE_W-1:0] side_sat;
   query_type   query;
   geom_type    geom;
   offset_type  offs;
   result_type  result;
   logic        geom_valid;
   logic        geom_ready;
   logic        offs_valid;
   logic        offs_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      side_sat = (csr_wdata > SIDE_MAX) ? SIDE_MAX : csr_wdata;
      cfg_in   = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPIRAL_WIDTH:   cfg_in.width      = side_sat;
            CSR_SPIRAL_HEIGHT:  cfg_in.height     = side_sat;
            CSR_MIRROR_COLUMNS: cfg_in.mirror     = csr_wdata[0];
            CSR_COUNT_DOWN:     cfg_in.count_down = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width      <= SIDE_W'(1);
         cfg_ff.height     <= SIDE_W'(1);
         cfg_ff.mirror     <= 1'b0;
         cfg_ff.count_down <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign query.row = req_tdata[3:0];
   assign query.col = req_tdata[7:4];

   scn_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (query),
      .out_valid (geom_valid),
      .out_ready (geom_ready),
      .out_data  (geom)
   );

   scn_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (geom_valid),
      .in_ready  (geom_ready),
      .in_data   (geom),
      .out_valid (offs_valid),
      .out_ready (offs_ready),
      .out_data  (offs)
   );

   scn_value u_value (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (offs_valid),
      .in_ready  (offs_ready),
      .in_data   (offs),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {7'd0, result.cell_value};
   assign rsp_tuser = result.out_of_range;

   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[8:0] == 9'd0)
      else $error("out of range word carries a nonzero value");

   a_value_bounds : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[8:0] != 9'd0 &&
         rsp_tdata[8:0] <= VALUE_W'({4'd0, cfg_ff.width} * {4'd0, cfg_ff.height}))
      else $error("spiral value outside one to grid area");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> geom_valid && offs_valid && rsp_tvalid && !rsp_tready)
      else $error("input stalled while the pipeline has room");

endmodule
`default_nettype wire
